>>> rtl/pzcs_pkg.sv
package pzcs_pkg;

    localparam int unsigned DIM_W       = 13;
    localparam int unsigned MAX_DIM     = 4096;
    localparam int unsigned SCALE_STEPS = 255;
    localparam int unsigned Q_W         = $clog2(SCALE_STEPS + 1);
    localparam int unsigned CHAIN_N     = SCALE_STEPS + 1;
    localparam int unsigned TIME_W      = 24;
    localparam int unsigned DUR_W       = 20;
    localparam int unsigned ZOOM_W      = 11;
    localparam int unsigned PAN_W       = 18;
    localparam int unsigned ORG_W       = 12;
    localparam int unsigned SCALE_W     = 8;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 20;

    // Crop size search: x = 16*t + q - 1, divided by q through a reciprocal.
    localparam int unsigned X_W         = DIM_W + 5;
    localparam int unsigned RECIP_SHIFT = X_W + 8;
    localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;

    // Desired scale divider numerator.
    localparam int unsigned NUM_W       = DIM_W + 5 + Q_W;

    // Pan origin arithmetic.
    localparam int unsigned PAN_ONE_SHIFT = 16;
    localparam int unsigned ORG_Q_W       = 13;
    localparam int unsigned ORG_NUM_W     = PAN_W + DIM_W + DUR_W + 4;
    localparam int unsigned REM_W         = ORG_NUM_W + 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ZOOM_START = 2'd0,
        CFG_ZOOM_END   = 2'd1,
        CFG_DURATION   = 2'd2,
        CFG_PAN        = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [DIM_W-1:0]  image_width;
        logic [DIM_W-1:0]  image_height;
        logic [DIM_W-1:0]  display_width;
        logic [DIM_W-1:0]  display_height;
        logic [TIME_W-1:0] elapsed_time;
    } t_req;

    typedef struct packed {
        logic               ok;
        logic [ORG_W-1:0]   crop_left;
        logic [ORG_W-1:0]   crop_top;
        logic [DIM_W-1:0]   crop_cols;
        logic [DIM_W-1:0]   crop_rows;
        logic [SCALE_W-1:0] scale_sixteenths;
    } t_res;

    // One request on its way through the candidate chain.
    typedef struct packed {
        logic              bad;
        logic [DIM_W-1:0]  sw;
        logic [DIM_W-1:0]  sh;
        logic [DIM_W-1:0]  tw;
        logic [DIM_W-1:0]  th;
        logic [TIME_W-1:0] el;
        logic [Q_W-1:0]    des;
        logic              lo_ok;
        logic [Q_W-1:0]    lo_q;
        logic [DIM_W-1:0]  lo_w;
        logic [DIM_W-1:0]  lo_h;
        logic              hi_ok;
        logic [Q_W-1:0]    hi_q;
        logic [DIM_W-1:0]  hi_w;
        logic [DIM_W-1:0]  hi_h;
        logic [X_W-1:0]    w;
        logic [X_W-1:0]    h;
    } t_cand;

endpackage

>>> rtl/pzcs_if.sv
interface pzcs_req_if;
    logic            valid;
    logic            ready;
    pzcs_pkg::t_req  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pzcs_res_if;
    logic            valid;
    logic            ready;
    pzcs_pkg::t_res  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/pan_zoom_crop_selector_unit.sv
// Pipeline from an accepted request word to its result word:
//   3 ratio stages, 8 desired-scale divider stages, 256 candidate stages,
//   20 selection, pan and origin divider stages.
// Throughput: one request word per cycle; a result word the sink does not take
//   goes to the output skid register and the whole pipeline stalls behind it.
// Reset: synchronous, active low; clears all valid bits and the skid, and loads
//   the configuration registers with their defaults. Payload is not reset.
module pan_zoom_crop_selector_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pzcs_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pzcs_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    pzcs_req_if.sink                            i_req,
    pzcs_res_if.source                          o_res
);
    import pzcs_pkg::*;

    localparam int unsigned PROD_W = 2 * DIM_W;

    typedef struct packed {
        logic              bad;
        logic [DIM_W-1:0]  sw;
        logic [DIM_W-1:0]  sh;
        logic [DIM_W-1:0]  tw;
        logic [DIM_W-1:0]  th;
        logic [TIME_W-1:0] el;
        logic [PROD_W-1:0] pa;
        logic [PROD_W-1:0] pb;
        logic [DIM_W-1:0]  den;
        logic [NUM_W-1:0]  rem;
        logic [Q_W-1:0]    quo;
        logic              ovf;
    } t_front;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [ZOOM_W-1:0]        r_zoom_start, r_zoom_end;
    logic [DUR_W-1:0]         r_duration;
    logic signed [PAN_W-1:0]  r_pan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zoom_start <= ZOOM_W'(256);
            r_zoom_end   <= ZOOM_W'(256);
            r_duration   <= DUR_W'(10000);
            r_pan        <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ZOOM_START: r_zoom_start <= i_cfg_data[ZOOM_W-1:0];
                CFG_ZOOM_END:   r_zoom_end   <= i_cfg_data[ZOOM_W-1:0];
                CFG_DURATION:   r_duration   <= i_cfg_data[DUR_W-1:0];
                CFG_PAN:        r_pan        <= $signed(i_cfg_data[PAN_W-1:0]);
                default:        r_pan        <= r_pan;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Global advance: the whole pipeline moves unless the skid holds a word.
    // ------------------------------------------------------------------
    logic   w_adv;
    logic   r_skid_v;
    t_res   r_skid;
    logic   w_p_v;
    t_res   w_p_res;

    assign w_adv       = !r_skid_v;
    assign i_req.ready = w_adv;

    // ------------------------------------------------------------------
    // Front end: pick the larger size ratio, then divide for the desired scale.
    // ------------------------------------------------------------------
    logic    r_f1_v, r_f2_v, r_f3_v;
    t_front  r_f1, r_f2, r_f3;
    t_front  n_f1, n_f2, n_f3;
    logic [DIM_W:0] zsum;

    always_comb begin
        n_f1     = '0;
        n_f1.sw  = i_req.data.image_width;
        n_f1.sh  = i_req.data.image_height;
        n_f1.tw  = i_req.data.display_width;
        n_f1.th  = i_req.data.display_height;
        n_f1.el  = i_req.data.elapsed_time;
        // any size out of 2..MAX_DIM, or no phase length, fails the request
        n_f1.bad = (n_f1.sw < DIM_W'(2)) || (n_f1.sh < DIM_W'(2))
                || (n_f1.tw < DIM_W'(2)) || (n_f1.th < DIM_W'(2))
                || (n_f1.sw > DIM_W'(MAX_DIM)) || (n_f1.sh > DIM_W'(MAX_DIM))
                || (n_f1.tw > DIM_W'(MAX_DIM)) || (n_f1.th > DIM_W'(MAX_DIM))
                || (r_duration == '0);
        n_f1.pa  = PROD_W'(n_f1.tw) * PROD_W'(n_f1.sh);
        n_f1.pb  = PROD_W'(n_f1.th) * PROD_W'(n_f1.sw);
    end

    // Larger of tw/sw and th/sh, times the zoom sum.
    always_comb begin
        zsum     = (DIM_W+1)'(r_zoom_start) + (DIM_W+1)'(r_zoom_end);
        n_f2     = r_f1;
        n_f2.den = (r_f1.pa >= r_f1.pb) ? r_f1.sw : r_f1.sh;
        n_f2.rem = NUM_W'((r_f1.pa >= r_f1.pb) ? r_f1.tw : r_f1.th) * NUM_W'(zsum);
    end

    // Add half the divisor for rounding; flag a quotient beyond the scale range.
    always_comb begin
        n_f3     = r_f2;
        n_f3.rem = r_f2.rem + NUM_W'({r_f2.den, 4'b0});
        n_f3.ovf = (n_f3.rem >= NUM_W'({r_f2.den, {(5+Q_W){1'b0}}}));
        n_f3.quo = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
            r_f2_v <= 1'b0;
            r_f3_v <= 1'b0;
        end else if (w_adv) begin
            r_f1_v <= i_req.valid;
            r_f2_v <= r_f1_v;
            r_f3_v <= r_f2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_f1 <= n_f1;
            r_f2 <= n_f2;
            r_f3 <= n_f3;
        end
    end

    // Restoring divider by 32*den, one scale bit per stage.
    logic [Q_W-1:0] r_fd_v;
    t_front         r_fd [Q_W];

    for (genvar j = 0; j < Q_W; j++) begin : g_des
        localparam int unsigned B = Q_W - 1 - j;
        logic             src_v;
        t_front           src, nxt;
        logic [NUM_W-1:0] dv;

        if (j == 0) begin : g_first
            assign src_v = r_f3_v;
            assign src   = r_f3;
        end else begin : g_next
            assign src_v = r_fd_v[j-1];
            assign src   = r_fd[j-1];
        end

        always_comb begin
            dv  = NUM_W'({src.den, 5'b0}) << B;
            nxt = src;
            if (src.rem >= dv) begin
                nxt.rem    = src.rem - dv;
                nxt.quo[B] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_fd_v[j] <= 1'b0;
            end else if (w_adv) begin
                r_fd_v[j] <= src_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_fd[j] <= nxt;
            end
        end
    end

    // ------------------------------------------------------------------
    // Candidate chain: stage k sizes the crop for scale k and checks
    // scale k-1, keeping the nearest passing scale on each side of desired.
    // ------------------------------------------------------------------
    logic   w_cv [CHAIN_N+1];
    t_cand  w_cd [CHAIN_N+1];

    always_comb begin
        w_cv[0]       = r_fd_v[Q_W-1];
        w_cd[0]       = '0;
        w_cd[0].bad   = r_fd[Q_W-1].bad;
        w_cd[0].sw    = r_fd[Q_W-1].sw;
        w_cd[0].sh    = r_fd[Q_W-1].sh;
        w_cd[0].tw    = r_fd[Q_W-1].tw;
        w_cd[0].th    = r_fd[Q_W-1].th;
        w_cd[0].el    = r_fd[Q_W-1].el;
        // clamp the desired scale to 1..SCALE_STEPS
        if (r_fd[Q_W-1].ovf || (r_fd[Q_W-1].quo > Q_W'(SCALE_STEPS))) begin
            w_cd[0].des = Q_W'(SCALE_STEPS);
        end else if (r_fd[Q_W-1].quo == '0) begin
            w_cd[0].des = Q_W'(1);
        end else begin
            w_cd[0].des = r_fd[Q_W-1].quo;
        end
    end

    for (genvar k = 1; k <= CHAIN_N; k++) begin : g_chain
        // the last stage only checks the top scale
        localparam int unsigned QK    = (k <= SCALE_STEPS) ? k : 0;
        localparam int unsigned QDIV  = (QK == 0) ? 1 : QK;
        localparam longint unsigned RECIP =
            (QK == 0) ? 0 : ((64'd1 << RECIP_SHIFT) + QDIV - 1) / QDIV;

        pzcs_cand_stage u_stage (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_adv),
            .i_q      (Q_W'(QK)),
            .i_q_prev (Q_W'(k - 1)),
            .i_recip  (RECIP_W'(RECIP)),
            .i_valid  (w_cv[k-1]),
            .i_cand   (w_cd[k-1]),
            .o_valid  (w_cv[k]),
            .o_cand   (w_cd[k])
        );
    end

    // ------------------------------------------------------------------
    // Selection and pan origin
    // ------------------------------------------------------------------
    pzcs_place u_place (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_adv),
        .i_duration (r_duration),
        .i_pan      (r_pan),
        .i_valid    (w_cv[CHAIN_N]),
        .i_cand     (w_cd[CHAIN_N]),
        .o_valid    (w_p_v),
        .o_res      (w_p_res)
    );

    // ------------------------------------------------------------------
    // Output skid: hold a result word the sink did not take, stall behind it.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (o_res.ready) begin
                r_skid_v <= 1'b0;
            end
        end else if (w_p_v && !o_res.ready) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_v) begin
            r_skid <= w_p_res;
        end
    end

    assign o_res.valid = r_skid_v || w_p_v;
    assign o_res.data  = r_skid_v ? r_skid : w_p_res;

endmodule

>>> rtl/pzcs_cand_stage.sv
module pzcs_cand_stage (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic [pzcs_pkg::Q_W-1:0]        i_q,
    input  logic [pzcs_pkg::Q_W-1:0]        i_q_prev,
    input  logic [pzcs_pkg::RECIP_W-1:0]    i_recip,
    input  logic                            i_valid,
    input  pzcs_pkg::t_cand                 i_cand,
    output logic                            o_valid,
    output pzcs_pkg::t_cand                 o_cand
);
    import pzcs_pkg::*;

    logic [X_W-1:0]         x_w, x_h;
    logic [X_W+RECIP_W-1:0] p_w, p_h;
    logic [X_W+Q_W-1:0]     m_w, m_h;
    logic [X_W-1:0]         lim_w, lim_h;
    logic                   ok_w, ok_h, c_ok;
    t_cand                  n_cand;
    logic                   r_valid;
    t_cand                  r_cand;

    // Crop size for this stage's scale: ceil(16*t / q).
    always_comb begin
        x_w = {1'b0, i_cand.tw, 4'b0} + X_W'(i_q) - X_W'(1);
        x_h = {1'b0, i_cand.th, 4'b0} + X_W'(i_q) - X_W'(1);
        p_w = (X_W+RECIP_W)'(x_w) * (X_W+RECIP_W)'(i_recip);
        p_h = (X_W+RECIP_W)'(x_h) * (X_W+RECIP_W)'(i_recip);
    end

    // Check the size that the previous stage produced for the previous scale.
    always_comb begin
        m_w   = (X_W+Q_W)'(i_cand.w) * (X_W+Q_W)'(i_q_prev);
        m_h   = (X_W+Q_W)'(i_cand.h) * (X_W+Q_W)'(i_q_prev);
        lim_w = {1'b0, i_cand.tw, 4'b0} + X_W'(16);
        lim_h = {1'b0, i_cand.th, 4'b0} + X_W'(16);
        ok_w  = (i_cand.w >= X_W'(2)) && (i_cand.w <= X_W'(i_cand.sw))
                && (m_w < (X_W+Q_W)'(lim_w));
        ok_h  = (i_cand.h >= X_W'(2)) && (i_cand.h <= X_W'(i_cand.sh))
                && (m_h < (X_W+Q_W)'(lim_h));
        c_ok  = ok_w && ok_h;
    end

    always_comb begin
        n_cand   = i_cand;
        n_cand.w = p_w[RECIP_SHIFT +: X_W];
        n_cand.h = p_h[RECIP_SHIFT +: X_W];
        // nearest passing scale at or below the desired one: keep the latest
        if (c_ok && (i_q_prev <= i_cand.des)) begin
            n_cand.lo_ok = 1'b1;
            n_cand.lo_q  = i_q_prev;
            n_cand.lo_w  = i_cand.w[DIM_W-1:0];
            n_cand.lo_h  = i_cand.h[DIM_W-1:0];
        end
        // nearest passing scale at or above: keep the first
        if (c_ok && (i_q_prev >= i_cand.des) && !i_cand.hi_ok) begin
            n_cand.hi_ok = 1'b1;
            n_cand.hi_q  = i_q_prev;
            n_cand.hi_w  = i_cand.w[DIM_W-1:0];
            n_cand.hi_h  = i_cand.h[DIM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cand <= n_cand;
        end
    end

    assign o_valid = r_valid;
    assign o_cand  = r_cand;

endmodule

>>> rtl/pzcs_place.sv
module pzcs_place (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic [pzcs_pkg::DUR_W-1:0]          i_duration,
    input  logic signed [pzcs_pkg::PAN_W-1:0]   i_pan,
    input  logic                                i_valid,
    input  pzcs_pkg::t_cand                     i_cand,
    output logic                                o_valid,
    output pzcs_pkg::t_res                      o_res
);
    import pzcs_pkg::*;

    localparam int unsigned PROD_W = 2 * DIM_W;

    typedef struct packed {
        logic                                  ok;
        logic [Q_W-1:0]                        q;
        logic [DIM_W-1:0]                      w;
        logic [DIM_W-1:0]                      h;
        logic [DIM_W-1:0]                      mx;
        logic [DIM_W-1:0]                      my;
        logic [TIME_W-1:0]                     el;
        logic                                  sel_x;
        logic [DIM_W-1:0]                      fp;
        logic [ORG_W-1:0]                      half;
        logic signed [DUR_W+1:0]               t;
        logic [DIM_W+DUR_W-1:0]                pa;
        logic signed [PAN_W+DIM_W:0]           pb;
        logic signed [PAN_W+DIM_W+DUR_W+2:0]   pc;
        logic                                  neg;
        logic [REM_W-1:0]                      rem;
        logic [ORG_Q_W-1:0]                    quo;
    } t_pan;

    // aspect products
    logic                r1_v;
    t_cand               r1_c;
    logic [PROD_W-1:0]   r1_lo1, r1_lo2, r1_hi1, r1_hi2;

    logic                r2_v, r3_v, r4_v, r5_v, r6_v;
    t_pan                r2, r3, r4, r5, r6;
    t_pan                n2, n3, n4, n5, n6;

    logic [ORG_Q_W-1:0]  r_dv_v;
    t_pan                r_dv [ORG_Q_W];

    logic                r_out_v;
    t_res                r_out, n_out;

    logic [PROD_W-1:0]   a_lo, a_hi;
    logic [Q_W-1:0]      d_lo, d_hi;
    logic                pick_hi;
    logic [19:0]         e_cl;
    logic signed [ORG_NUM_W-1:0] num;
    logic [ORG_NUM_W-1:0]        mag;
    logic [ORG_Q_W-1:0]  org;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r3_v    <= 1'b0;
            r4_v    <= 1'b0;
            r5_v    <= 1'b0;
            r6_v    <= 1'b0;
            r_out_v <= 1'b0;
        end else if (i_en) begin
            r1_v    <= i_valid;
            r2_v    <= r1_v;
            r3_v    <= r2_v;
            r4_v    <= r3_v;
            r5_v    <= r4_v;
            r6_v    <= r5_v;
            r_out_v <= r_dv_v[ORG_Q_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_c   <= i_cand;
            r1_lo1 <= PROD_W'(i_cand.lo_w) * PROD_W'(i_cand.th);
            r1_lo2 <= PROD_W'(i_cand.lo_h) * PROD_W'(i_cand.tw);
            r1_hi1 <= PROD_W'(i_cand.hi_w) * PROD_W'(i_cand.th);
            r1_hi2 <= PROD_W'(i_cand.hi_h) * PROD_W'(i_cand.tw);
            r2     <= n2;
            r3     <= n3;
            r4     <= n4;
            r5     <= n5;
            r6     <= n6;
            r_out  <= n_out;
        end
    end

    // Pick between the nearest scale below and above; aspect error breaks ties.
    always_comb begin
        a_lo    = (r1_lo1 > r1_lo2) ? (r1_lo1 - r1_lo2) : (r1_lo2 - r1_lo1);
        a_hi    = (r1_hi1 > r1_hi2) ? (r1_hi1 - r1_hi2) : (r1_hi2 - r1_hi1);
        d_lo    = r1_c.des - r1_c.lo_q;
        d_hi    = r1_c.hi_q - r1_c.des;
        pick_hi = r1_c.hi_ok && (!r1_c.lo_ok || (d_hi < d_lo)
                  || ((d_hi == d_lo) && (a_hi < a_lo)));
        n2      = '0;
        n2.ok   = (r1_c.lo_ok || r1_c.hi_ok) && !r1_c.bad;
        n2.q    = pick_hi ? r1_c.hi_q : r1_c.lo_q;
        n2.w    = pick_hi ? r1_c.hi_w : r1_c.lo_w;
        n2.h    = pick_hi ? r1_c.hi_h : r1_c.lo_h;
        n2.mx   = r1_c.sw - n2.w;
        n2.my   = r1_c.sh - n2.h;
        n2.el   = r1_c.el;
    end

    // Pan axis, half offset for the other axis, signed progress term 2e - D.
    always_comb begin
        n3       = r2;
        n3.sel_x = (r2.mx >= r2.my);
        n3.fp    = n3.sel_x ? r2.mx : r2.my;
        n3.half  = ORG_W'(((DIM_W+1)'(n3.sel_x ? r2.my : r2.mx) + (DIM_W+1)'(1)) >> 1);
        e_cl     = (r2.el < TIME_W'(i_duration)) ? r2.el[DUR_W-1:0] : i_duration;
        n3.t     = $signed({1'b0, e_cl, 1'b0}) - $signed({2'b0, i_duration});
    end

    always_comb begin
        n4    = r3;
        n4.pa = (DIM_W+DUR_W)'(r3.fp) * (DIM_W+DUR_W)'(i_duration);
        n4.pb = i_pan * $signed({1'b0, r3.fp});
    end

    always_comb begin
        n5    = r4;
        n5.pc = r4.pb * r4.t;
    end

    // Numerator, then 2*|num| + den for round half away from zero.
    always_comb begin
        n6     = r5;
        num    = $signed(ORG_NUM_W'({r5.pa, {PAN_ONE_SHIFT{1'b0}}})) + ORG_NUM_W'(r5.pc);
        mag    = num[ORG_NUM_W-1] ? ORG_NUM_W'(-num) : ORG_NUM_W'(num);
        n6.neg = num[ORG_NUM_W-1];
        n6.rem = REM_W'({mag, 1'b0}) + REM_W'({i_duration, {(PAN_ONE_SHIFT+1){1'b0}}});
        n6.quo = '0;
    end

    // Restoring divider by 2^18*D, one quotient bit per stage.
    for (genvar j = 0; j < ORG_Q_W; j++) begin : g_div
        localparam int unsigned B = ORG_Q_W - 1 - j;
        logic             src_v;
        t_pan             src, nxt;
        logic [REM_W-1:0] dv;

        if (j == 0) begin : g_first
            assign src_v = r6_v;
            assign src   = r6;
        end else begin : g_next
            assign src_v = r_dv_v[j-1];
            assign src   = r_dv[j-1];
        end

        always_comb begin
            dv  = REM_W'({i_duration, {(PAN_ONE_SHIFT+2){1'b0}}}) << B;
            nxt = src;
            if (src.rem >= dv) begin
                nxt.rem    = src.rem - dv;
                nxt.quo[B] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[j] <= 1'b0;
            end else if (i_en) begin
                r_dv_v[j] <= src_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv[j] <= nxt;
            end
        end
    end

    // Clamp to 0..free and place on the panned axis; zero everything on failure.
    always_comb begin
        if (r_dv[ORG_Q_W-1].neg) begin
            org = '0;
        end else if (r_dv[ORG_Q_W-1].quo > ORG_Q_W'(r_dv[ORG_Q_W-1].fp)) begin
            org = ORG_Q_W'(r_dv[ORG_Q_W-1].fp);
        end else begin
            org = r_dv[ORG_Q_W-1].quo;
        end
        n_out = '0;
        if (r_dv[ORG_Q_W-1].ok) begin
            n_out.ok               = 1'b1;
            n_out.crop_left        = r_dv[ORG_Q_W-1].sel_x ? org[ORG_W-1:0]
                                                          : r_dv[ORG_Q_W-1].half;
            n_out.crop_top         = r_dv[ORG_Q_W-1].sel_x ? r_dv[ORG_Q_W-1].half
                                                          : org[ORG_W-1:0];
            n_out.crop_cols        = r_dv[ORG_Q_W-1].w;
            n_out.crop_rows        = r_dv[ORG_Q_W-1].h;
            n_out.scale_sixteenths = SCALE_W'(r_dv[ORG_Q_W-1].q);
        end
    end

    assign o_valid = r_out_v;
    assign o_res   = r_out;

endmodule

>>> tb/tb_pan_zoom_crop_selector_unit.sv
`timescale 1ns / 100ps

module tb_pan_zoom_crop_selector_unit;
    import pzcs_pkg::*;

    // Pipeline depth as given by the design header. Allow a margin on top of it.
    localparam int unsigned PIPE_LAT    = 287;
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned HOLD_CYCLES = 900;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    pzcs_req_if req_if ();
    pzcs_res_if res_if ();

    pan_zoom_crop_selector_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if.sink),
        .o_res      (res_if.source)
    );

    // Directed rows: expectation typed in only where it is obvious.
    typedef struct {
        t_req req;
        bit   typed;
        t_res res;
    } t_row;

    // Shadow of the configuration registers.
    longint unsigned zoom_start_sh;
    longint unsigned zoom_end_sh;
    longint unsigned duration_sh;
    longint          pan_sh;

    t_res        crop_due_q[$];
    t_row        rows[$];
    int unsigned n_errors;
    int unsigned n_results;
    int unsigned n_found;
    int unsigned n_words;
    int unsigned n_cycles;
    bit          calm;
    bit          hold_ask;
    int unsigned hold_left;

    // Clock and run limit.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results still due",
                     $time, n_cycles, crop_due_q.size());
            $display("tb_pan_zoom_crop_selector_unit NOT OK");
            $finish;
        end
    end

    // Round half away from zero; den is positive.
    function automatic longint round_half_away(longint num, longint den);
        if (num >= 0)
            return (2 * num + den) / (2 * den);
        return -((2 * (-num) + den) / (2 * den));
    endfunction

    // Origin along one axis for a pan fraction, clamped to the free room.
    function automatic longint unsigned pan_origin_px(longint unsigned free_px, longint pan,
                                                      longint unsigned e, longint unsigned d);
        longint num;
        longint r;
        num = longint'(free_px * 65536 * d) + pan * longint'(free_px)
              * (longint'(2 * e) - longint'(d));
        r = round_half_away(num, longint'(131072 * d));
        if (r < 0)
            return 0;
        if (longint'(free_px) < r)
            return free_px;
        return longint'(r);
    endfunction

    // Expected crop window for one request under the current registers.
    function automatic t_res predict_crop(t_req r);
        longint unsigned sw, sh, tw, th, el;
        longint unsigned num, den, des, q, w, h, serr, a1, a2, aerr, score;
        longint unsigned top_score, best_q, best_w, best_h, mx, my, e, cx, cy;
        t_res res;
        res = '0;
        sw = r.image_width;
        sh = r.image_height;
        tw = r.display_width;
        th = r.display_height;
        el = r.elapsed_time;
        if (sw < 2 || sh < 2 || tw < 2 || th < 2 || sw > MAX_DIM || sh > MAX_DIM ||
            tw > MAX_DIM || th > MAX_DIM || duration_sh == 0)
            return res;
        if (tw * sh >= th * sw) begin
            num = tw;
            den = sw;
        end else begin
            num = th;
            den = sh;
        end
        des = (2 * num * (zoom_start_sh + zoom_end_sh) + 32 * den) / (64 * den);
        if (des < 1)
            des = 1;
        if (des > SCALE_STEPS)
            des = SCALE_STEPS;
        top_score = '1;
        best_q = 0;
        best_w = 0;
        best_h = 0;
        for (q = 1; q <= SCALE_STEPS; q++) begin
            w = (tw * 16 + q - 1) / q;
            h = (th * 16 + q - 1) / q;
            if (w < 2 || h < 2 || w > sw || h > sh)
                continue;
            if ((w * q) / 16 != tw || (h * q) / 16 != th)
                continue;
            serr = (q > des) ? q - des : des - q;
            a1 = w * th;
            a2 = h * tw;
            aerr = (a1 > a2) ? a1 - a2 : a2 - a1;
            score = serr * 64'd1000000000 + aerr;
            if (score < top_score) begin
                top_score = score;
                best_q = q;
                best_w = w;
                best_h = h;
            end
        end
        if (best_q == 0)
            return res;
        mx = sw - best_w;
        my = sh - best_h;
        e = (el < duration_sh) ? el : duration_sh;
        // Pan the axis with more free room; the other one sits centered.
        if (mx >= my && mx > 0) begin
            cx = pan_origin_px(mx, pan_sh, e, duration_sh);
            cy = pan_origin_px(my, 0, e, duration_sh);
        end else if (my > 0) begin
            cx = pan_origin_px(mx, 0, e, duration_sh);
            cy = pan_origin_px(my, pan_sh, e, duration_sh);
        end else begin
            cx = 0;
            cy = 0;
        end
        res.ok = 1'b1;
        res.crop_left = cx[ORG_W-1:0];
        res.crop_top = cy[ORG_W-1:0];
        res.crop_cols = best_w[DIM_W-1:0];
        res.crop_rows = best_h[DIM_W-1:0];
        res.scale_sixteenths = best_q[SCALE_W-1:0];
        return res;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            n_errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    // Receiver: random stalls, a calm stretch, and one long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            hold_left = 0;
        end else if (hold_left > 0) begin
            res_if.ready <= 1'b0;
            hold_left--;
        end else if (hold_ask) begin
            hold_left = HOLD_CYCLES;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= calm || ($urandom_range(99) >= 12);
        end
    end

    // Compare each result word with the oldest expectation.
    always @(posedge i_clk) begin
        t_res want;
        t_res got;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = res_if.data;
            if (crop_due_q.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result word, got %p", $time, got);
            end else begin
                want = crop_due_q.pop_front();
                n_results++;
                if (got.ok)
                    n_found++;
                check_field("ok", want.ok, got.ok);
                check_field("crop_left", want.crop_left, got.crop_left);
                check_field("crop_top", want.crop_top, got.crop_top);
                check_field("crop_cols", want.crop_cols, got.crop_cols);
                check_field("crop_rows", want.crop_rows, got.crop_rows);
                check_field("scale_sixteenths", want.scale_sixteenths,
                            got.scale_sixteenths);
            end
        end
    end

    // Write one register and track it in the shadow copy.
    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_ZOOM_START: zoom_start_sh = value[ZOOM_W-1:0];
            CFG_ZOOM_END:   zoom_end_sh = value[ZOOM_W-1:0];
            CFG_DURATION:   duration_sh = value[DUR_W-1:0];
            CFG_PAN:        pan_sh = longint'($signed(value[PAN_W-1:0]));
            default:        pan_sh = pan_sh;
        endcase
    endtask

    task automatic write_all(int unsigned zs, int unsigned ze, int unsigned dur, int pan);
        logic [PAN_W-1:0] pan_bits;
        pan_bits = pan[PAN_W-1:0];
        write_reg(CFG_ZOOM_START, CFG_DATA_W'(zs));
        write_reg(CFG_ZOOM_END, CFG_DATA_W'(ze));
        write_reg(CFG_DURATION, CFG_DATA_W'(dur));
        write_reg(CFG_PAN, CFG_DATA_W'(pan_bits));
    endtask

    // Offer one word, hold it until accepted, then record what is due.
    // Leave valid high afterwards; the next call decides whether to drop it.
    task automatic send_word(t_req r, bit typed, t_res typed_res);
        while (!calm && $urandom_range(99) < 12) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        @(posedge i_clk);
        while (!req_if.ready)
            @(posedge i_clk);
        crop_due_q.push_back(typed ? typed_res : predict_crop(r));
        n_words++;
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        while (crop_due_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic add_row(int unsigned sw, int unsigned sh, int unsigned tw,
                           int unsigned th, int unsigned el, bit typed, t_res res);
        t_row row;
        row.req.image_width    = DIM_W'(sw);
        row.req.image_height   = DIM_W'(sh);
        row.req.display_width  = DIM_W'(tw);
        row.req.display_height = DIM_W'(th);
        row.req.elapsed_time   = TIME_W'(el);
        row.typed = typed;
        row.res = res;
        rows.push_back(row);
    endtask

    function automatic int unsigned pick_dim();
        // Favor modest sizes, reach the top now and then.
        case ($urandom_range(3))
            0:       return $urandom_range(2, 64);
            1:       return $urandom_range(2, 640);
            2:       return $urandom_range(2, 2048);
            default: return $urandom_range(2, MAX_DIM);
        endcase
    endfunction

    function automatic t_req random_req();
        t_req r;
        int unsigned kind;
        int unsigned lim;
        kind = $urandom_range(99);
        r.image_width  = DIM_W'(pick_dim());
        r.image_height = DIM_W'(pick_dim());
        lim = r.image_width * 15;
        r.display_width = DIM_W'($urandom_range(2, (lim < MAX_DIM) ? lim : MAX_DIM));
        lim = r.image_height * 15;
        r.display_height = DIM_W'($urandom_range(2, (lim < MAX_DIM) ? lim : MAX_DIM));
        if ($urandom_range(3) != 0)
            r.elapsed_time = TIME_W'($urandom_range(0, duration_sh));
        else
            r.elapsed_time = TIME_W'($urandom());
        if (kind < 8) begin
            // Noise: any bits at all.
            r = t_req'($bits(t_req)'({$urandom(), $urandom(), $urandom()}));
        end else if (kind < 14) begin
            // Break one size: too small or beyond the limit.
            lim = ($urandom_range(1)) ? $urandom_range(0, 1)
                                      : $urandom_range(MAX_DIM + 1, 8191);
            case ($urandom_range(3))
                0:       r.image_width = DIM_W'(lim);
                1:       r.image_height = DIM_W'(lim);
                2:       r.display_width = DIM_W'(lim);
                default: r.display_height = DIM_W'(lim);
            endcase
        end
        return r;
    endfunction

    initial begin
        t_res none;
        t_res full;
        t_res tiny;
        int   pan_pick;
        none = '0;
        full = '{ok: 1'b1, crop_left: '0, crop_top: '0, crop_cols: DIM_W'(4096),
                 crop_rows: DIM_W'(4096), scale_sixteenths: SCALE_W'(16)};
        tiny = '{ok: 1'b1, crop_left: '0, crop_top: '0, crop_cols: DIM_W'(2),
                 crop_rows: DIM_W'(2), scale_sixteenths: SCALE_W'(16)};
        n_errors = 0;
        n_results = 0;
        n_found = 0;
        n_words = 0;
        n_cycles = 0;
        calm = 1'b0;
        hold_ask = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_ZOOM_START;
        i_cfg_data = '0;
        req_if.valid = 1'b0;
        req_if.data = '0;
        zoom_start_sh = 256;
        zoom_end_sh = 256;
        duration_sh = 10000;
        pan_sh = 0;

        // Directed rows: invalid sizes on every field, extremes, late requests,
        // upscale and downscale, free room on one axis only.
        add_row(0, 100, 50, 50, 0, 1, none);
        add_row(100, 1, 50, 50, 0, 1, none);
        add_row(100, 100, 1, 50, 0, 1, none);
        add_row(100, 100, 50, 0, 0, 1, none);
        add_row(8191, 100, 50, 50, 0, 1, none);
        add_row(100, 4097, 50, 50, 0, 1, none);
        add_row(100, 100, 8191, 50, 0, 1, none);
        add_row(100, 100, 50, 4097, 0, 1, none);
        add_row(4096, 4096, 4096, 4096, 0, 1, full);
        add_row(2, 2, 2, 2, 16777215, 1, tiny);
        add_row(4096, 2, 2, 2, 0, 0, none);
        add_row(2, 4096, 2, 2, 10000, 0, none);
        add_row(2, 2, 4096, 4096, 0, 0, none);
        add_row(4096, 4096, 2, 2, 5000, 0, none);
        add_row(640, 480, 320, 240, 0, 0, none);
        add_row(640, 480, 320, 240, 10000, 0, none);
        add_row(640, 480, 320, 240, 16777215, 0, none);
        add_row(1920, 1080, 800, 480, 2500, 0, none);
        add_row(480, 640, 240, 400, 7777, 0, none);
        add_row(100, 100, 1500, 1500, 3, 0, none);
        add_row(37, 91, 13, 29, 9999, 0, none);
        add_row(3, 4096, 3, 1000, 1234, 0, none);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k])
            send_word(rows[k].req, rows[k].typed, rows[k].res);
        drain();

        // Random phases, each under its own register setting.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: write_all(0, 0, 1, -65536);
                1: write_all(2047, 2047, 1048575, 65536);
                2: write_all(1024, 0, 0, 1000);
                3: write_all(256, 256, 10000, 131071);
                4: write_all(0, 1024, 1000, -131072);
                5: write_all(128, 384, 40000, 32768);
                default: begin
                    pan_pick = int'($urandom_range(0, 262143)) - 131072;
                    write_all($urandom_range(0, 2047), $urandom_range(0, 2047),
                              $urandom_range(1, 1048575), pan_pick);
                end
            endcase
            calm = (ph == 3);
            for (int k = 0; k < 150; k++) begin
                // Hold the receiver off once while words keep coming in.
                if (ph == 5 && k == 10)
                    hold_ask <= 1'b1;
                else if (ph == 5 && k == 11)
                    hold_ask <= 1'b0;
                send_word(random_req(), 0, none);
            end
            calm = 1'b0;
            drain();
        end

        repeat (PIPE_LAT + 20) @(posedge i_clk);

        $display("Sent %0d request words under 9 register settings, including a long",
                 n_words);
        $display("output hold-off; %0d results checked, %0d with a crop found.",
                 n_results, n_found);
        if (n_errors == 0 && crop_due_q.size() == 0) begin
            $display("tb_pan_zoom_crop_selector_unit OK");
        end else begin
            $display("%0d mismatches, %0d results never arrived", n_errors,
                     crop_due_q.size());
            $display("tb_pan_zoom_crop_selector_unit NOT OK");
        end
        $finish;
    end

endmodule
